// ===== design/keyed_counter_min_heap_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Keyed counter min-heap assertion macros
// Shared helpers that wrap a concurrent assertion on clock and reset.
// ----------------------------------------------------------------------------
`ifndef KEYED_COUNTER_MIN_HEAP_UNIT_MACROS_SVH
`define KEYED_COUNTER_MIN_HEAP_UNIT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define KCMH_ASSERT(name, expr, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Property whose consequent must hold in the cycle after the antecedent.
`define KCMH_ASSERT_NEXT(name, pre, post, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

// ===== design/kcmh_pkg.sv =====
// ----------------------------------------------------------------------------
// Keyed counter min-heap package
// Sizes, action and status codes, and the types shared by the heap modules.
// ----------------------------------------------------------------------------
package kcmh_pkg;

   // Number of heap positions (a power of two) and stored payload width.
   localparam int CAPACITY     = 256;
   localparam int PAYLOAD_BITS = 32;

   // Heap position, entry count and child index widths.
   localparam int POS_BITS = $clog2(CAPACITY);
   localparam int CNT_BITS = POS_BITS + 1;
   localparam int IDX_BITS = POS_BITS + 2;

   // The key search encodes its match vector in groups of GRP_SIZE cells.
   localparam int GRP_BITS = POS_BITS / 2;
   localparam int GRP_SIZE = 1 << GRP_BITS;
   localparam int NUM_GRP  = CAPACITY >> GRP_BITS;
   localparam int HI_BITS  = POS_BITS - GRP_BITS;

   typedef enum logic [2:0] {
      ACT_INSERT = 3'd0,
      ACT_INCR   = 3'd1,
      ACT_SET    = 3'd2,
      ACT_POP    = 3'd3,
      ACT_FIND   = 3'd4
   } action_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_DUP     = 3'd1,
      ST_FULL    = 3'd2,
      ST_EMPTY   = 3'd3,
      ST_MISSING = 3'd4
   } status_type;

   // One counter as held at a heap position.
   typedef struct packed {
      logic [31:0]             key;
      logic [63:0]             value;
      logic [PAYLOAD_BITS-1:0] tag;
   } entry_type;

   // Key update sent to the search cells along with every heap write.
   typedef struct packed {
      logic                en;
      logic [POS_BITS-1:0] pos;
      logic [31:0]         key;
   } cam_write_type;

   // Outcome of a key search.
   typedef struct packed {
      logic                found;
      logic [POS_BITS-1:0] pos;
   } cam_result_type;

endpackage

// ===== design/kcmh_channels.sv =====
// ----------------------------------------------------------------------------
// Keyed counter min-heap channels
// Valid/ready interfaces for request and response transactions.
// ----------------------------------------------------------------------------
interface kcmh_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         action;
   logic signed [31:0] key;
   logic [63:0]        value_in;
   logic [31:0]        payload;

   modport source (output valid, action, key, value_in, payload, input ready);
   modport sink (input valid, action, key, value_in, payload, output ready);
endinterface

interface kcmh_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         status;
   logic signed [31:0] key_out;
   logic [63:0]        value_out;
   logic [31:0]        payload_out;
   logic [8:0]         count;

   modport source (output valid, status, key_out, value_out, payload_out, count,
                   input ready);
   modport sink (input valid, status, key_out, value_out, payload_out, count,
                 output ready);
endinterface

// ===== design/kcmh_cell.sv =====
// ----------------------------------------------------------------------------
// Keyed counter min-heap search cell
// Mirrors the key of one heap position and compares it with the probe key.
// ----------------------------------------------------------------------------
module kcmh_cell (
   input  logic                          clock,
   input  logic [kcmh_pkg::POS_BITS-1:0] index,
   input  kcmh_pkg::cam_write_type       wr,
   input  logic [31:0]                   probe_key,
   input  logic [kcmh_pkg::CNT_BITS-1:0] count,
   output logic                          match_ff
);
   import kcmh_pkg::*;

   logic [31:0] key_ff;

   // Follow heap writes to this position and flag a live key match.
   always_ff @(posedge clock) begin
      if (wr.en && (wr.pos == index)) begin
         key_ff <= wr.key;
      end
      match_ff <= (key_ff == probe_key) && ({1'b0, index} < count);
   end

endmodule

// ===== design/kcmh_cam.sv =====
// ----------------------------------------------------------------------------
// Keyed counter min-heap key search
// A row of search cells followed by a two-level registered match encoder.
// ----------------------------------------------------------------------------
module kcmh_cam (
   input  logic                          clock,
   input  kcmh_pkg::cam_write_type       wr,
   input  logic [31:0]                   probe_key,
   input  logic [kcmh_pkg::CNT_BITS-1:0] count,
   output kcmh_pkg::cam_result_type      result_ff
);
   import kcmh_pkg::*;

   logic [CAPACITY-1:0] match;
   logic [NUM_GRP-1:0]  grp_hit_in;
   logic [NUM_GRP-1:0]  grp_hit_ff;
   logic [GRP_BITS-1:0] grp_idx_in [NUM_GRP];
   logic [GRP_BITS-1:0] grp_idx_ff [NUM_GRP];
   cam_result_type      result_in;

   // One cell per heap position.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      kcmh_cell u_cell (
         .clock     (clock),
         .index     (POS_BITS'(i)),
         .wr        (wr),
         .probe_key (probe_key),
         .count     (count),
         .match_ff  (match[i])
      );
   end

   // Keys are unique among live positions, so at most one bit is set and
   // the position can be built by OR-ing indexes.
   always_comb begin
      for (int g = 0; g < NUM_GRP; g++) begin
         grp_hit_in[g] = 1'b0;
         grp_idx_in[g] = '0;
         for (int j = 0; j < GRP_SIZE; j++) begin
            if (match[g * GRP_SIZE + j]) begin
               grp_hit_in[g] = 1'b1;
               grp_idx_in[g] = grp_idx_in[g] | GRP_BITS'(j);
            end
         end
      end
   end

   // Second level merges the group results.
   always_comb begin
      result_in = '0;
      for (int g = 0; g < NUM_GRP; g++) begin
         if (grp_hit_ff[g]) begin
            result_in.found = 1'b1;
            result_in.pos   = result_in.pos | {HI_BITS'(g), grp_idx_ff[g]};
         end
      end
   end

   always_ff @(posedge clock) begin
      grp_hit_ff <= grp_hit_in;
      grp_idx_ff <= grp_idx_in;
      result_ff  <= result_in;
   end

endmodule

// ===== design/keyed_counter_min_heap_unit.sv =====
// ----------------------------------------------------------------------------
// Keyed counter min-heap unit
// Up to CAPACITY keyed 64-bit counters in a binary min-heap ordered by value.
// ----------------------------------------------------------------------------
// Requests arrive on req_ch (action, key, value_in, payload) and each one
// produces exactly one response on rsp_ch (status, key_out, value_out,
// payload_out, count). One request is processed at a time: req_ch.ready is
// high while the unit waits for work.
// Every request first runs a key search over the row of search cells. A
// sift then moves one heap level per cycle through the heap memory (two read
// ports, one write port). Undefined actions and error cases but a duplicate
// insert are answered straight after the search; a find, an update that
// changes nothing, an insert into an empty heap or a pop of the only entry
// run no sift, and the longest case is a sift over the full depth of the
// heap. Once the response is registered the unit returns to idle and can
// accept the next request. The response sits in an output register; a new
// request is accepted while it waits, and the unit stalls before delivering
// the next response until the receiver takes the previous one.
// Reset empties the heap at once; the heap memory needs no clearing pass.
// ----------------------------------------------------------------------------
`include "keyed_counter_min_heap_unit_macros.svh"

module keyed_counter_min_heap_unit (
   input logic      clock,
   input logic      reset,
   kcmh_req_if.sink   req_ch,
   kcmh_rsp_if.source rsp_ch
);
   import kcmh_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MATCH,
      S_GROUP,
      S_FINAL,
      S_DECIDE,
      S_LOAD,
      S_POPRD,
      S_UP,
      S_DOWN,
      S_PLACE,
      S_RESP
   } state_type;

   state_type               state_ff, state_in;
   logic [2:0]              op_act_ff, op_act_in;
   logic [31:0]             op_key_ff, op_key_in;
   logic [63:0]             op_val_ff, op_val_in;
   logic [PAYLOAD_BITS-1:0] op_tag_ff, op_tag_in;
   logic [CNT_BITS-1:0]     count_ff, count_in;
   logic [POS_BITS-1:0]     hole_ff, hole_in;
   entry_type               item_ff, item_in;
   status_type              res_status_ff, res_status_in;
   entry_type               res_entry_ff, res_entry_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [2:0]              rsp_status_ff, rsp_status_in;
   logic [31:0]             rsp_key_ff, rsp_key_in;
   logic [63:0]             rsp_value_ff, rsp_value_in;
   logic [31:0]             rsp_tag_ff, rsp_tag_in;
   logic [CNT_BITS-1:0]     rsp_count_ff, rsp_count_in;

   entry_type               heap_mem [CAPACITY];
   entry_type               rd_a_ff, rd_b_ff;
   logic [POS_BITS-1:0]     rd_a_addr, rd_b_addr;
   logic                    mem_wr_en;
   logic [POS_BITS-1:0]     mem_wr_pos;
   entry_type               mem_wr_entry;

   cam_write_type           cam_wr;
   cam_result_type          cam_res;

   logic [IDX_BITS-1:0]     count_ix;
   logic [IDX_BITS-1:0]     left_ix, right_ix, next_left;
   logic [POS_BITS-1:0]     par_pos, sel_pos;
   logic [63:0]             upd_value;
   logic                    bump, take_right;
   entry_type               child;

   function automatic logic [IDX_BITS-1:0] child_left(input logic [POS_BITS-1:0] p);
      return {1'b0, p, 1'b1};
   endfunction

   function automatic logic [POS_BITS-1:0] parent_of(input logic [POS_BITS-1:0] p);
      return (p - 1'b1) >> 1;
   endfunction

   // Key search over the heap positions.
   assign cam_wr = '{en: mem_wr_en, pos: mem_wr_pos, key: mem_wr_entry.key};

   kcmh_cam u_cam (
      .clock     (clock),
      .wr        (cam_wr),
      .probe_key (op_key_ff),
      .count     (count_ff),
      .result_ff (cam_res)
   );

   // Heap memory: one write and two registered reads per cycle.
   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         heap_mem[mem_wr_pos] <= mem_wr_entry;
      end
      rd_a_ff <= heap_mem[rd_a_addr];
      rd_b_ff <= heap_mem[rd_b_addr];
   end

   // Helpers for the sift steps.
   assign count_ix   = {1'b0, count_ff};
   assign left_ix    = child_left(hole_ff);
   assign right_ix   = left_ix + 1'b1;
   assign par_pos    = parent_of(hole_ff);
   assign upd_value  = (op_act_ff == ACT_INCR) ? (rd_a_ff.value + op_val_ff) : op_val_ff;
   assign bump       = ((op_act_ff == ACT_INCR) && (op_val_ff != '0)) ||
                       ((op_act_ff == ACT_SET) && (op_val_ff != rd_a_ff.value));
   assign take_right = (right_ix < count_ix) && (rd_b_ff.value < rd_a_ff.value);
   assign child      = take_right ? rd_b_ff : rd_a_ff;
   assign sel_pos    = take_right ? right_ix[POS_BITS-1:0] : left_ix[POS_BITS-1:0];
   assign next_left  = child_left(sel_pos);

   // Request sequencer.
   always_comb begin
      state_in      = state_ff;
      op_act_in     = op_act_ff;
      op_key_in     = op_key_ff;
      op_val_in     = op_val_ff;
      op_tag_in     = op_tag_ff;
      count_in      = count_ff;
      hole_in       = hole_ff;
      item_in       = item_ff;
      res_status_in = res_status_ff;
      res_entry_in  = res_entry_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_count_in  = rsp_count_ff;
      rd_a_addr     = '0;
      rd_b_addr     = '0;
      mem_wr_en     = 1'b0;
      mem_wr_pos    = hole_ff;
      mem_wr_entry  = item_ff;

      // The receiver took the pending response.
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               op_act_in = req_ch.action;
               op_key_in = req_ch.key;
               op_val_in = req_ch.value_in;
               op_tag_in = req_ch.payload[PAYLOAD_BITS-1:0];
               state_in  = S_MATCH;
            end
         end
         S_MATCH: state_in = S_GROUP;
         S_GROUP: state_in = S_FINAL;
         S_FINAL: state_in = S_DECIDE;
         S_DECIDE: begin
            res_status_in = ST_OK;
            res_entry_in  = '0;
            state_in      = S_RESP;
            case (op_act_ff) inside
               ACT_INSERT: begin
                  if (cam_res.found) begin
                     res_status_in = ST_DUP;
                     rd_a_addr     = cam_res.pos;
                     state_in      = S_LOAD;
                  end else if (count_ff == CNT_BITS'(CAPACITY)) begin
                     res_status_in = ST_FULL;
                  end else begin
                     item_in      = '{key: op_key_ff, value: op_val_ff, tag: op_tag_ff};
                     res_entry_in = item_in;
                     hole_in      = count_ff[POS_BITS-1:0];
                     count_in     = count_ff + 1'b1;
                     if (count_ff == '0) begin
                        state_in = S_PLACE;
                     end else begin
                        rd_a_addr = parent_of(count_ff[POS_BITS-1:0]);
                        state_in  = S_UP;
                     end
                  end
               end
               ACT_INCR, ACT_SET, ACT_FIND: begin
                  if (!cam_res.found) begin
                     res_status_in = ST_MISSING;
                  end else begin
                     rd_a_addr = cam_res.pos;
                     hole_in   = cam_res.pos;
                     state_in  = S_LOAD;
                  end
               end
               ACT_POP: begin
                  if (count_ff == '0) begin
                     res_status_in = ST_EMPTY;
                  end else begin
                     count_in  = count_ff - 1'b1;
                     rd_a_addr = '0;
                     rd_b_addr = count_in[POS_BITS-1:0];
                     state_in  = S_POPRD;
                  end
               end
               default: begin
                  // Undefined actions only report the count.
                  state_in = S_RESP;
               end
            endcase
         end
         S_LOAD: begin
            if (!bump) begin
               res_entry_in = rd_a_ff;
               state_in     = S_RESP;
            end else begin
               item_in      = '{key: rd_a_ff.key, value: upd_value, tag: rd_a_ff.tag};
               res_entry_in = item_in;
               if (upd_value < rd_a_ff.value) begin
                  if (hole_ff == '0) begin
                     state_in = S_PLACE;
                  end else begin
                     rd_a_addr = par_pos;
                     state_in  = S_UP;
                  end
               end else if (left_ix >= count_ix) begin
                  state_in = S_PLACE;
               end else begin
                  rd_a_addr = left_ix[POS_BITS-1:0];
                  rd_b_addr = right_ix[POS_BITS-1:0];
                  state_in  = S_DOWN;
               end
            end
         end
         S_POPRD: begin
            // The old root is the result; the last entry refills the root.
            res_entry_in = rd_a_ff;
            item_in      = rd_b_ff;
            hole_in      = '0;
            if (count_ff == '0) begin
               state_in = S_RESP;
            end else if (child_left('0) >= count_ix) begin
               state_in = S_PLACE;
            end else begin
               rd_a_addr = POS_BITS'(1);
               rd_b_addr = POS_BITS'(2);
               state_in  = S_DOWN;
            end
         end
         S_UP: begin
            // Move the parent down while the carried entry is smaller.
            if (item_ff.value >= rd_a_ff.value) begin
               state_in = S_PLACE;
            end else begin
               mem_wr_en    = 1'b1;
               mem_wr_entry = rd_a_ff;
               hole_in      = par_pos;
               if (par_pos == '0) begin
                  state_in = S_PLACE;
               end else begin
                  rd_a_addr = parent_of(par_pos);
               end
            end
         end
         S_DOWN: begin
            // Move the smaller child up while it is below the carried entry.
            if (item_ff.value <= child.value) begin
               state_in = S_PLACE;
            end else begin
               mem_wr_en    = 1'b1;
               mem_wr_entry = child;
               hole_in      = sel_pos;
               if (next_left >= count_ix) begin
                  state_in = S_PLACE;
               end else begin
                  rd_a_addr = next_left[POS_BITS-1:0];
                  rd_b_addr = next_left[POS_BITS-1:0] + 1'b1;
               end
            end
         end
         S_PLACE: begin
            mem_wr_en = 1'b1;
            state_in  = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_key_in    = res_entry_ff.key;
               rsp_value_in  = res_entry_ff.value;
               rsp_tag_in    = 32'(res_entry_ff.tag);
               rsp_count_in  = count_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_act_ff     <= op_act_in;
      op_key_ff     <= op_key_in;
      op_val_ff     <= op_val_in;
      op_tag_ff     <= op_tag_in;
      hole_ff       <= hole_in;
      item_ff       <= item_in;
      res_status_ff <= res_status_in;
      res_entry_ff  <= res_entry_in;
      rsp_status_ff <= rsp_status_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // Port drive.
   assign req_ch.ready       = (state_ff == S_IDLE);
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.key_out     = rsp_key_ff;
   assign rsp_ch.value_out   = rsp_value_ff;
   assign rsp_ch.payload_out = rsp_tag_ff;
   assign rsp_ch.count       = rsp_count_ff;

   // Checks on the sequencer.
   `KCMH_ASSERT(a_count_bound, count_ff <= CNT_BITS'(CAPACITY), "entry count above capacity")
   `KCMH_ASSERT_NEXT(a_accept_search, req_ch.valid && req_ch.ready, state_ff == S_MATCH, "accepted transaction did not start a key search")
   `KCMH_ASSERT(a_write_state, !mem_wr_en || (state_ff == S_UP) || (state_ff == S_DOWN) || (state_ff == S_PLACE), "heap write outside a sift")
   `KCMH_ASSERT(a_rsp_source, !$rose(rsp_valid_ff) || ($past(state_ff) == S_RESP), "response raised outside the response state")

endmodule

// ===== verif/keyed_counter_min_heap_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Keyed counter min-heap unit testbench
// Drives insert, increment, set, pop, find and reserved actions into the heap
// with random idle bursts on both channels. Directed rows or a behavioral
// heap give each response, which is checked field by field in arrival order.
// ----------------------------------------------------------------------------
module keyed_counter_min_heap_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import kcmh_pkg::*;

   // Action codes that the unit must ignore.
   localparam logic [2:0] ACT_RSVD5 = 3'd5;
   localparam logic [2:0] ACT_RSVD6 = 3'd6;
   localparam logic [2:0] ACT_RSVD7 = 3'd7;

   localparam int RANDOM_ITEMS = 800;
   localparam int FILL_ITEMS   = 350;
   localparam int QUIET_ITEMS  = 100;
   localparam int DRAIN_CYCLES = 40;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int NUM_ROWS     = 24;

   typedef struct packed {
      logic [2:0]  action;
      logic [31:0] key;
      logic [63:0] value_in;
      logic [31:0] payload;
   } heap_request_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] key_out;
      logic [63:0] value_out;
      logic [31:0] payload_out;
      logic [8:0]  count;
   } heap_response_type;

   // One directed row; the response is given only where it is obvious.
   typedef struct packed {
      heap_request_type  req;
      logic              typed;
      heap_response_type rsp;
   } directed_row_type;

   logic clock;
   logic reset;
   int   cycle_count = 0;
   int   error_count = 0;
   bit   idle_enable;

   heap_response_type expected_rsps[$];

   kcmh_req_if req_ch ();
   kcmh_rsp_if rsp_ch ();

   keyed_counter_min_heap_unit i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Shadow heap state.
   logic [31:0] shadow_key [CAPACITY];
   logic [63:0] shadow_value [CAPACITY];
   logic [31:0] shadow_tag [CAPACITY];
   int          shadow_pos [CAPACITY];
   bit          shadow_used [CAPACITY];
   int          shadow_slot [CAPACITY];
   int          shadow_count;

   function automatic void heap_swap(int a, int b);
      int ea;
      int eb;
      ea = shadow_slot[a];
      eb = shadow_slot[b];
      shadow_slot[a] = eb;
      shadow_slot[b] = ea;
      shadow_pos[eb] = a;
      shadow_pos[ea] = b;
   endfunction

   function automatic void heap_rise(int pos);
      int parent;
      while (pos > 0) begin
         parent = (pos - 1) / 2;
         if (shadow_value[shadow_slot[pos]] >= shadow_value[shadow_slot[parent]]) break;
         heap_swap(pos, parent);
         pos = parent;
      end
   endfunction

   function automatic void heap_sink(int pos);
      int l;
      int s;
      forever begin
         l = 2 * pos + 1;
         s = l;
         if (l >= shadow_count) break;
         if (l + 1 < shadow_count &&
             shadow_value[shadow_slot[l+1]] < shadow_value[shadow_slot[l]]) s = l + 1;
         if (shadow_value[shadow_slot[pos]] <= shadow_value[shadow_slot[s]]) break;
         heap_swap(pos, s);
         pos = s;
      end
   endfunction

   function automatic int find_entry(logic [31:0] k);
      for (int i = 0; i < CAPACITY; i++)
         if (shadow_used[i] && shadow_key[i] == k) return i;
      return -1;
   endfunction

   function automatic void revalue(int e, logic [63:0] nv);
      logic [63:0] old;
      old = shadow_value[e];
      if (nv == old) return;
      shadow_value[e] = nv;
      if (nv < old) heap_rise(shadow_pos[e]);
      else heap_sink(shadow_pos[e]);
   endfunction

   // Applies one request to the shadow heap and returns its response.
   function automatic heap_response_type heap_apply(heap_request_type r);
      heap_response_type o;
      int                e;
      int                m;
      int                last;
      bit                have;
      o = '0;
      o.status = ST_OK;
      e = -1;
      have = 1'b0;
      case (r.action) inside
         ACT_INSERT: begin
            e = find_entry(r.key);
            if (e >= 0) begin
               o.status = ST_DUP;
               have = 1'b1;
            end else if (shadow_count >= CAPACITY) begin
               o.status = ST_FULL;
            end else begin
               for (int i = 0; i < CAPACITY; i++)
                  if (!shadow_used[i]) begin
                     e = i;
                     break;
                  end
               shadow_used[e] = 1'b1;
               shadow_key[e] = r.key;
               shadow_value[e] = r.value_in;
               shadow_tag[e] = r.payload;
               shadow_pos[e] = shadow_count;
               shadow_slot[shadow_count] = e;
               shadow_count++;
               heap_rise(shadow_pos[e]);
               have = 1'b1;
            end
         end
         ACT_INCR, ACT_SET, ACT_FIND: begin
            e = find_entry(r.key);
            if (e < 0) begin
               o.status = ST_MISSING;
            end else begin
               if (r.action == ACT_INCR && r.value_in != 0)
                  revalue(e, shadow_value[e] + r.value_in);
               else if (r.action == ACT_SET)
                  revalue(e, r.value_in);
               have = 1'b1;
            end
         end
         ACT_POP: begin
            if (shadow_count == 0) begin
               o.status = ST_EMPTY;
            end else begin
               m = shadow_slot[0];
               o.key_out = shadow_key[m];
               o.value_out = shadow_value[m];
               o.payload_out = shadow_tag[m];
               shadow_used[m] = 1'b0;
               shadow_count--;
               if (shadow_count > 0) begin
                  last = shadow_slot[shadow_count];
                  shadow_slot[0] = last;
                  shadow_pos[last] = 0;
                  heap_sink(0);
               end
            end
         end
         default: ;
      endcase
      if (have) begin
         o.key_out = shadow_key[e];
         o.value_out = shadow_value[e];
         o.payload_out = shadow_tag[e];
      end
      o.count = shadow_count[8:0];
      return o;
   endfunction

   task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
      $display("[%0d] mismatch on %s: got %0h, expected %0h", cycle_count, field, got, want);
      error_count++;
   endtask

   // Response checking against the oldest expectation.
   always @(posedge clock) begin
      heap_response_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_rsps.size() == 0) begin
            report_mismatch("unexpected response", 64'd1, 64'd0);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_ch.status !== want.status)
               report_mismatch("status", rsp_ch.status, want.status);
            if (rsp_ch.key_out !== want.key_out)
               report_mismatch("key_out", rsp_ch.key_out, want.key_out);
            if (rsp_ch.value_out !== want.value_out)
               report_mismatch("value_out", rsp_ch.value_out, want.value_out);
            if (rsp_ch.payload_out !== want.payload_out)
               report_mismatch("payload_out", rsp_ch.payload_out, want.payload_out);
            if (rsp_ch.count !== want.count)
               report_mismatch("count", rsp_ch.count, want.count);
         end
      end
   end

   // Cycle counter and timeout.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // Receiver stalls in short bursts.
   initial begin
      rsp_ch.ready <= 1'b0;
      @(negedge reset);
      @(posedge clock);
      rsp_ch.ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (idle_enable && $urandom_range(0, 3) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Sends one request, possibly after an idle burst, and records its response.
   task automatic send_request(heap_request_type r, bit typed,
                               heap_response_type typed_rsp);
      heap_response_type predicted;
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.action <= r.action;
      req_ch.key <= r.key;
      req_ch.value_in <= r.value_in;
      req_ch.payload <= r.payload;
      do @(posedge clock); while (!req_ch.ready);
      predicted = heap_apply(r);
      expected_rsps.push_back(typed ? typed_rsp : predicted);
   endtask

   function automatic logic [63:0] pick_value();
      case ($urandom_range(0, 9)) inside
         0, 1, 2: return 64'($urandom_range(0, 15));
         3, 4:    return 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 15));
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic logic [2:0] pick_action(bit filling);
      int roll;
      roll = $urandom_range(0, 99);
      if (filling) return roll < 80 ? ACT_INSERT : 3'(ACT_INCR + roll % 4);
      if (roll < 30) return ACT_POP;
      if (roll < 50) return ACT_INCR;
      if (roll < 65) return ACT_SET;
      if (roll < 80) return ACT_FIND;
      if (roll < 95) return ACT_INSERT;
      case (roll % 3)
         0:       return ACT_RSVD5;
         1:       return ACT_RSVD6;
         default: return ACT_RSVD7;
      endcase
   endfunction

   directed_row_type rows [NUM_ROWS];

   // Stimulus.
   initial begin
      heap_request_type r;
      idle_enable = 1'b1;
      shadow_count = 0;
      for (int i = 0; i < CAPACITY; i++) shadow_used[i] = 1'b0;
      req_ch.valid = 1'b0;
      req_ch.action = ACT_INSERT;
      req_ch.key = '0;
      req_ch.value_in = '0;
      req_ch.payload = '0;

      // Directed rows: empty-heap errors, key and value extremes, wrap,
      // zero delta, equal set, duplicate key and the reserved actions.
      rows[0]  = '{'{ACT_POP, 32'h0, 64'h0, 32'h0}, 1'b1, '{ST_EMPTY, 0, 0, 0, 9'd0}};
      rows[1]  = '{'{ACT_FIND, 32'h5, 64'h0, 32'h0}, 1'b1, '{ST_MISSING, 0, 0, 0, 9'd0}};
      rows[2]  = '{'{ACT_INCR, 32'h5, 64'h1, 32'h0}, 1'b1, '{ST_MISSING, 0, 0, 0, 9'd0}};
      rows[3]  = '{'{ACT_SET, 32'h5, 64'h1, 32'h0}, 1'b1, '{ST_MISSING, 0, 0, 0, 9'd0}};
      rows[4]  = '{'{ACT_INSERT, 32'h8000_0000, '1, '1}, 1'b1,
                   '{ST_OK, 32'h8000_0000, '1, '1, 9'd1}};
      rows[5]  = '{'{ACT_INSERT, 32'h7FFF_FFFF, 64'h0, 32'h0}, 1'b1,
                   '{ST_OK, 32'h7FFF_FFFF, 64'h0, 32'h0, 9'd2}};
      rows[6]  = '{'{ACT_INSERT, 32'h8000_0000, 64'h5, 32'h1}, 1'b1,
                   '{ST_DUP, 32'h8000_0000, '1, '1, 9'd2}};
      rows[7]  = '{'{ACT_INCR, 32'h7FFF_FFFF, 64'h0, 32'h0}, 1'b1,
                   '{ST_OK, 32'h7FFF_FFFF, 64'h0, 32'h0, 9'd2}};
      rows[8]  = '{'{ACT_INCR, 32'h8000_0000, 64'h2, 32'h0}, 1'b0, '0};
      rows[9]  = '{'{ACT_SET, 32'h7FFF_FFFF, 64'h7, 32'h0}, 1'b0, '0};
      rows[10] = '{'{ACT_SET, 32'h7FFF_FFFF, 64'h7, 32'h0}, 1'b0, '0};
      rows[11] = '{'{ACT_FIND, 32'h8000_0000, 64'h0, 32'h0}, 1'b0, '0};
      rows[12] = '{'{ACT_RSVD5, 32'h1, 64'h1, 32'h1}, 1'b1, '{ST_OK, 0, 0, 0, 9'd2}};
      rows[13] = '{'{ACT_RSVD6, 32'h1, 64'h1, 32'h1}, 1'b1, '{ST_OK, 0, 0, 0, 9'd2}};
      rows[14] = '{'{ACT_RSVD7, '1, '1, '1}, 1'b1, '{ST_OK, 0, 0, 0, 9'd2}};
      rows[15] = '{'{ACT_INSERT, 32'h0, 64'h3, 32'h1234_5678}, 1'b0, '0};
      rows[16] = '{'{ACT_INSERT, 32'hFFFF_FFFF, 64'h3, 32'hA5A5_A5A5}, 1'b0, '0};
      rows[17] = '{'{ACT_INCR, 32'h0, '1, 32'h0}, 1'b0, '0};
      rows[18] = '{'{ACT_SET, 32'hFFFF_FFFF, 64'hFFFF_FFFF_0000_0000, 32'h0}, 1'b0, '0};
      rows[19] = '{'{ACT_POP, '1, '1, '1}, 1'b0, '0};
      rows[20] = '{'{ACT_POP, 32'h0, 64'h0, 32'h0}, 1'b0, '0};
      rows[21] = '{'{ACT_POP, 32'h0, 64'h0, 32'h0}, 1'b0, '0};
      rows[22] = '{'{ACT_POP, 32'h0, 64'h0, 32'h0}, 1'b0, '0};
      rows[23] = '{'{ACT_POP, 32'h0, 64'h0, 32'h0}, 1'b1, '{ST_EMPTY, 0, 0, 0, 9'd0}};

      reset = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) send_request(rows[i].req, rows[i].typed, rows[i].rsp);

      // Random part: first mostly inserts to fill the heap, then a mix that
      // drains and reshapes it. Keys come mostly from a small pool so that
      // duplicates and hits are common.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS - QUIET_ITEMS) idle_enable = 1'b0;
         r.action = pick_action(n < FILL_ITEMS);
         r.key = $urandom_range(0, 9) == 0 ? $urandom : 32'($urandom_range(0, 399) - 200);
         r.value_in = pick_value();
         r.payload = $urandom;
         send_request(r, 1'b0, '0);
      end
      req_ch.valid <= 1'b0;

      wait (expected_rsps.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_rsps.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
